// ===== sv/dda_pkg.sv =====
// Shared constants, types and helper functions of the dipole diffusion accumulator.
// Depends on nothing; the divider, queue, front end, back end and top level import it.
package dda_pkg;

  // Fixed-point format of positions, depths, irradiance and area.
  localparam int unsigned FRACTION_BITS = 16;

  // Widths of the datapath.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned DIVD_W  = 64 + FRACTION_BITS;

  // Q31 constants, the exponent cutoff and the saturation limits.
  localparam logic [31:0] ONE_Q31         = 32'h8000_0000;
  localparam logic [31:0] INV_FOUR_PI_Q31 = 32'd170891319;
  localparam logic [63:0] EXP_CUTOFF      = 64'd22;
  localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [63:0] QF_HI_LIM       = {64{1'b1}} >> (32 - FRACTION_BITS);

  // Alignment of the exponent argument, which arrives in Q(2F).
  localparam int unsigned EXP_FRAC_W = 2 * FRACTION_BITS;
  localparam logic [63:0] EXP_FRAC_MASK = (64'd1 << EXP_FRAC_W) - 64'd1;
  localparam int unsigned EXP_SH_DN = (EXP_FRAC_W >= 31) ? EXP_FRAC_W - 31 : 0;
  localparam int unsigned EXP_SH_UP = (EXP_FRAC_W >= 31) ? 0 : 31 - EXP_FRAC_W;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_REAL_DEPTH    = 3'd0,
    CFG_VIRTUAL_DEPTH = 3'd1,
    CFG_EXTINCTION    = 3'd2,
    CFG_QUERY_X       = 3'd3,
    CFG_QUERY_Y       = 3'd4,
    CFG_QUERY_Z       = 3'd5
  } cfg_idx_e;

  // Register file contents.
  typedef struct packed {
    logic [31:0] real_source_depth;
    logic [31:0] virtual_source_depth;
    logic [31:0] transport_extinction;
    logic [31:0] query_x;
    logic [31:0] query_y;
    logic [31:0] query_z;
  } cfg_t;

  // One classified sample as handed from the front to the back.
  typedef struct packed {
    logic [63:0] r2;
    logic [31:0] irradiance;
    logic [31:0] patch_area;
    logic        final_sample;
  } work_t;

  // Saturating 64-bit add.
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // floor(2^32 / k) for the Horner divisors 1 to 14.
  function automatic logic [32:0] recip_k(input logic [3:0] k);
    logic [32:0] r;
    case (k)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      4'd13:   r = 33'd330382099;
      4'd14:   r = 33'd306783378;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Series value of e^-f in Q31, used only to fix e^-1 at elaboration.
  function automatic logic [63:0] exp_neg_frac_c(input logic [63:0] f);
    logic [63:0] t;
    t = 64'(ONE_Q31);
    for (int k = 14; k >= 1; k--) begin
      t = 64'(ONE_Q31) - ((f * t) >> 31) / 64'(k);
    end
    return t;
  endfunction

  localparam logic [31:0] EM1_Q31 = 32'(exp_neg_frac_c(64'(ONE_Q31)));

endpackage

// ===== sv/dda_in_if.sv =====
// Input channel of the dipole diffusion accumulator: one irradiance sample per transfer.
// Self-contained; used by the top level and the front end.
interface dda_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_x;
  logic signed [31:0] sample_y;
  logic signed [31:0] sample_z;
  logic        [31:0] irradiance;
  logic        [31:0] patch_area;
  logic               final_sample;

  modport source (
    output valid, sample_x, sample_y, sample_z, irradiance, patch_area, final_sample,
    input  ready
  );
  modport sink (
    input  valid, sample_x, sample_y, sample_z, irradiance, patch_area, final_sample,
    output ready
  );
endinterface

// ===== sv/dda_out_if.sv =====
// Output channel of the dipole diffusion accumulator: one running sum per transfer.
// Self-contained; used by the top level and the back end.
interface dda_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] running_sum;
  logic        sum_complete;

  modport source (output valid, running_sum, sum_complete, input ready);
  modport sink   (input valid, running_sum, sum_complete, output ready);
endinterface

// ===== sv/dda_divider.sv =====
// Bit-serial restoring divider: DIVD_W-bit dividend by a 32-bit divisor, saturated quotient.
// Depends on dda_pkg.
module dda_divider import dda_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [31:0]       divisor_i,
  output logic              busy_o,
  output logic [63:0]       quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVD_W);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVD_W-1:0] num_q;
  logic [31:0]       rem_q;
  logic [31:0]       den_q;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        q_bit;

  // One quotient bit per cycle.
  always_comb begin
    rem_sh  = {rem_q, num_q[DIVD_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    q_bit   = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIVD_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[DIVD_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = (|num_q[DIVD_W-1:64]) ? {64{1'b1}} : num_q[63:0];

endmodule

// ===== sv/dda_queue.sv =====
// Two-entry queue that decouples the sample front end from the diffusion back end.
// Depends on dda_pkg for the work item type.
module dda_queue import dda_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output work_t pop_data_o,
  output logic  empty_o
);

  work_t       mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;
  logic        do_push;
  logic        do_pop;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/dda_front.sv =====
// Front end: accepts samples and forms the saturated squared distance to the query point.
// Depends on dda_pkg and dda_in_if; feeds dda_queue.
module dda_front import dda_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  dda_in_if.sink in_i,
  input  cfg_t   cfg_i,
  output logic   push_o,
  output work_t  push_data_o,
  input  logic   full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQ,
    F_PUSH
  } front_state_e;

  front_state_e state_q;
  logic [1:0]   cnt_q;
  logic [31:0]  mag_q [3];
  logic [63:0]  prod_q;
  work_t        work_q;

  logic [31:0] mag_x;
  logic [31:0] mag_y;
  logic [31:0] mag_z;

  // Capped magnitude of a coordinate difference.
  function automatic logic [31:0] diff_mag(input logic [31:0] q, input logic [31:0] s);
    logic signed [32:0] d;
    logic        [32:0] m;
    d = $signed({q[31], q}) - $signed({s[31], s});
    m = d[32] ? 33'(-d) : 33'(d);
    return m[32] ? 32'hFFFF_FFFF : m[31:0];
  endfunction

  always_comb begin
    mag_x = diff_mag(cfg_i.query_x, in_i.sample_x);
    mag_y = diff_mag(cfg_i.query_y, in_i.sample_y);
    mag_z = diff_mag(cfg_i.query_z, in_i.sample_z);
  end

  assign in_i.ready  = (state_q == F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !full_i;
  assign push_data_o = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_i.valid) begin
            cnt_q   <= '0;
            state_q <= F_SQ;
          end
        end
        F_SQ: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // Square one magnitude per cycle, add the previous square into r2.
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_i.valid) begin
      mag_q[0]             <= mag_x;
      mag_q[1]             <= mag_y;
      mag_q[2]             <= mag_z;
      work_q.r2            <= '0;
      work_q.irradiance    <= in_i.irradiance;
      work_q.patch_area    <= in_i.patch_area;
      work_q.final_sample  <= in_i.final_sample;
    end else if (state_q == F_SQ) begin
      prod_q   <= mag_q[0] * mag_q[0];
      mag_q[0] <= mag_q[1];
      mag_q[1] <= mag_q[2];
      mag_q[2] <= '0;
      if (cnt_q != 2'd0) begin
        work_q.r2 <= sat_add64(work_q.r2, prod_q);
      end
    end
  end

endmodule

// ===== sv/dda_back.sv =====
// Back end: per sample, evaluates both dipole source terms on one shared multiplier and
// one shared divider, scales and accumulates. Depends on dda_pkg, dda_divider, dda_out_if.
module dda_back import dda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        empty_i,
  input  work_t       pop_data_i,
  output logic        pop_o,
  dda_out_if.source   out_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_ZSQ, S_RAD, S_SQRT, S_DCHK, S_U_WAIT, S_EXP_X,
    S_H1, S_H2, S_H3, S_EPOW, S_EPOW2, S_V, S_V2, S_P, S_P_WAIT,
    S_W_WAIT, S_Q_WAIT, S_T1, S_T2, S_T3, S_M1, S_M2, S_M3, S_ACC
  } back_state_e;

  back_state_e   state_q;
  work_t         item_q;
  logic          src_sel_q;
  logic          pass_q;
  logic [64:0]   prod_q;
  logic [63:0]   rad_q;
  logic [31:0]   root_q;
  logic [32:0]   rem_q;
  logic [4:0]    sq_cnt_q;
  logic [31:0]   u_q;
  logic [31:0]   f_q;
  logic [31:0]   t_q;
  logic [31:0]   p_q;
  logic [3:0]    k_q;
  logic [4:0]    n_q;
  logic [31:0]   v_q;
  logic [63:0]   pdiv_q;
  logic [63:0]   term_q;
  logic [63:0]   hi_q;
  logic [63:0]   a_q;
  logic [SUM_W-1:0] acc_q;
  logic          out_valid_q;
  logic [SUM_W-1:0] out_sum_q;
  logic          out_complete_q;

  logic [31:0]       z;
  logic [31:0]       b_sel;
  logic [32:0]       mul_a;
  logic [31:0]       mul_b;
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic              div_busy;
  logic [63:0]       div_quot;

  logic [34:0] sq_rem_sh;
  logic [34:0] sq_trial;
  logic        sq_take;
  logic [63:0] exp_x;
  logic [63:0] exp_n;
  logic [63:0] exp_f;
  logic [31:0] h_q0;
  logic [35:0] h_qk;
  logic [31:0] h_rem;
  logic [31:0] h_quot;
  logic [63:0] src_val;
  logic [63:0] qf_lo;
  logic [63:0] qf_res;
  logic [63:0] sum_full;
  logic [SUM_W-1:0] sum_sat;
  logic        out_free;

  assign z     = src_sel_q ? cfg_i.virtual_source_depth : cfg_i.real_source_depth;
  assign b_sel = pass_q ? item_q.patch_area : item_q.irradiance;

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ZSQ:    begin mul_a = 33'(z);              mul_b = z; end
      S_U_WAIT: begin mul_a = 33'(cfg_i.transport_extinction); mul_b = root_q; end
      S_H1:     begin mul_a = 33'(f_q);            mul_b = t_q; end
      S_H2:     begin mul_a = recip_k(k_q);        mul_b = prod_q[62:31]; end
      S_EPOW:   begin mul_a = 33'(t_q);            mul_b = EM1_Q31; end
      S_V:      begin mul_a = 33'(u_q);            mul_b = t_q; end
      S_V2:     begin mul_a = 33'(prod_q[62:31]);  mul_b = cfg_i.transport_extinction; end
      S_T1:     begin mul_a = term_q[63:31];       mul_b = INV_FOUR_PI_Q31; end
      S_T2:     begin mul_a = {2'b00, term_q[30:0]}; mul_b = INV_FOUR_PI_Q31; end
      S_M1:     begin mul_a = 33'(a_q[63:32]);     mul_b = b_sel; end
      S_M2:     begin mul_a = 33'(a_q[31:0]);      mul_b = b_sel; end
      default:  begin mul_a = '0;                  mul_b = '0; end
    endcase
  end

  // Divider requests: z/d, v*sigma/d, v/d and (v/d)/d, the last two scaled by 2^F.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    case (state_q)
      S_DCHK: begin
        div_start    = (root_q != '0);
        div_dividend = DIVD_W'(z) << 31;
      end
      S_P: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'(prod_q[63:0]);
      end
      S_P_WAIT: begin
        div_start    = !div_busy;
        div_dividend = DIVD_W'(v_q) << FRACTION_BITS;
      end
      S_W_WAIT: begin
        div_start    = !div_busy;
        div_dividend = {div_quot, {FRACTION_BITS{1'b0}}};
      end
      default: begin
        div_start    = 1'b0;
        div_dividend = '0;
      end
    endcase
  end

  dda_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (root_q),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // Datapath helpers for the current state.
  always_comb begin
    // Square root, two radicand bits per step.
    sq_rem_sh = {rem_q[32:0], rad_q[63:62]};
    sq_trial  = {1'b0, root_q, 2'b01};
    sq_take   = (sq_rem_sh >= sq_trial);
    // Exponent argument split into integer part and Q31 fraction.
    exp_x = prod_q[63:0];
    exp_n = exp_x >> EXP_FRAC_W;
    exp_f = ((exp_x & EXP_FRAC_MASK) >> EXP_SH_DN) << EXP_SH_UP;
    // Horner divide by k through the reciprocal, with one correction step.
    h_q0   = prod_q[63:32];
    h_qk   = h_q0 * k_q;
    h_rem  = p_q - h_qk[31:0];
    h_quot = (h_rem >= 32'(k_q)) ? h_q0 + 32'd1 : h_q0;
    // Source term brought back from Q31 to QF.
    src_val = sat_add64(pdiv_q, div_quot) >> (31 - FRACTION_BITS);
    // QF product of a wide value and a 32-bit factor.
    qf_lo  = prod_q[63:0];
    qf_res = (hi_q > QF_HI_LIM) ? {64{1'b1}} :
             sat_add64(hi_q << (32 - FRACTION_BITS), qf_lo >> FRACTION_BITS);
    // Accumulation with saturation at the sum width.
    sum_full = sat_add64(64'(acc_q), a_q);
    sum_sat  = (sum_full > 64'(SUM_MAX)) ? SUM_MAX : sum_full[SUM_W-1:0];
  end

  assign out_free          = !out_valid_q || out_o.ready;
  assign pop_o             = (state_q == S_IDLE) && !empty_i;
  assign out_o.valid       = out_valid_q;
  assign out_o.running_sum = out_sum_q;
  assign out_o.sum_complete = out_complete_q;

  // Sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      src_sel_q   <= 1'b0;
      pass_q      <= 1'b0;
    end else begin
      // The accumulate step loads a new result itself when the register drains.
      if (out_valid_q && out_o.ready && state_q != S_ACC) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            item_q    <= pop_data_i;
            term_q    <= '0;
            src_sel_q <= 1'b0;
            pass_q    <= 1'b0;
            state_q   <= S_ZSQ;
          end
        end
        S_ZSQ: state_q <= S_RAD;
        S_RAD: begin
          rad_q    <= sat_add64(item_q.r2, prod_q[63:0]);
          root_q   <= '0;
          rem_q    <= '0;
          sq_cnt_q <= '0;
          state_q  <= S_SQRT;
        end
        S_SQRT: begin
          rad_q    <= {rad_q[61:0], 2'b00};
          rem_q    <= sq_take ? 33'(sq_rem_sh - sq_trial) : sq_rem_sh[32:0];
          root_q   <= {root_q[30:0], sq_take};
          sq_cnt_q <= sq_cnt_q + 5'd1;
          if (sq_cnt_q == 5'd31) begin
            state_q <= S_DCHK;
          end
        end
        S_DCHK: begin
          if (root_q != '0) begin
            state_q <= S_U_WAIT;
          end else if (!src_sel_q) begin
            src_sel_q <= 1'b1;
            state_q   <= S_ZSQ;
          end else begin
            state_q <= S_T1;
          end
        end
        S_U_WAIT: begin
          if (!div_busy) begin
            u_q     <= div_quot[31:0];
            state_q <= S_EXP_X;
          end
        end
        S_EXP_X: begin
          if (exp_n >= EXP_CUTOFF) begin
            t_q     <= '0;
            state_q <= S_V;
          end else begin
            n_q     <= exp_n[4:0];
            f_q     <= exp_f[31:0];
            t_q     <= ONE_Q31;
            k_q     <= 4'd14;
            state_q <= S_H1;
          end
        end
        S_H1: state_q <= S_H2;
        S_H2: begin
          p_q     <= prod_q[62:31];
          state_q <= S_H3;
        end
        S_H3: begin
          t_q <= ONE_Q31 - h_quot;
          k_q <= k_q - 4'd1;
          state_q <= (k_q == 4'd1) ? S_EPOW : S_H1;
        end
        S_EPOW: begin
          state_q <= (n_q == '0) ? S_V : S_EPOW2;
        end
        S_EPOW2: begin
          t_q     <= prod_q[62:31];
          n_q     <= n_q - 5'd1;
          state_q <= S_EPOW;
        end
        S_V:  state_q <= S_V2;
        S_V2: begin
          v_q     <= prod_q[62:31];
          state_q <= S_P;
        end
        S_P:  state_q <= S_P_WAIT;
        S_P_WAIT: begin
          if (!div_busy) begin
            pdiv_q  <= div_quot;
            state_q <= S_W_WAIT;
          end
        end
        S_W_WAIT: begin
          if (!div_busy) begin
            state_q <= S_Q_WAIT;
          end
        end
        S_Q_WAIT: begin
          if (!div_busy) begin
            term_q <= sat_add64(term_q, src_val);
            if (!src_sel_q) begin
              src_sel_q <= 1'b1;
              state_q   <= S_ZSQ;
            end else begin
              state_q <= S_T1;
            end
          end
        end
        S_T1: state_q <= S_T2;
        S_T2: begin
          hi_q    <= prod_q[63:0];
          state_q <= S_T3;
        end
        S_T3: begin
          a_q     <= hi_q + (prod_q[63:0] >> 31);
          state_q <= S_M1;
        end
        S_M1: state_q <= S_M2;
        S_M2: begin
          hi_q    <= prod_q[63:0];
          state_q <= S_M3;
        end
        S_M3: begin
          a_q <= qf_res;
          if (pass_q) begin
            state_q <= S_ACC;
          end else begin
            pass_q  <= 1'b1;
            state_q <= S_M1;
          end
        end
        S_ACC: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_sum_q      <= sum_sat;
            out_complete_q <= item_q.final_sample;
            acc_q          <= item_q.final_sample ? '0 : sum_sat;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

endmodule

// ===== sv/dipole_diffusion_accumulator.sv =====
// Dipole diffusion accumulator for one spectral channel.
// Samples enter on in_i (valid/ready); each accepted sample yields one transfer on out_o
// carrying the running sum including that sample, with sum_complete copied from
// final_sample. After a final sample the accumulator returns to zero.
// The front end forms r^2 for one sample at a time and takes the next only after pushing
// the last; a two-entry queue holds classified samples while the back end works. The back
// end also handles one sample at a time; its time per sample grows with n, the integer
// part of the extinction times d for each source. A source at zero distance skips its
// terms, and one with n of 22 or more skips the series. The time is set by the shared
// bit-serial divider, which runs four divisions of 64 + FRACTION_BITS steps per source,
// and by the 14-step exponential series. Configuration is written through cfg_we_i /
// cfg_idx_i / cfg_data_i; the user must write it only while idle, and the block itself
// does not enforce this. Unknown indexes are ignored. Reset (rst_ni low, asynchronous)
// restores the default registers (depths and extinction 1.0, query point at the origin)
// and clears the sum.
// When the receiver stalls, the result waits in the output register; the back end then
// stops before the accumulate step, and the queue and front end fill and back-pressure.
// Depends on dda_pkg, dda_in_if, dda_out_if, dda_front, dda_queue and dda_back.
module dipole_diffusion_accumulator import dda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dda_in_if.sink      in_i,
  dda_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  push;
  logic  full;
  logic  pop;
  logic  empty;
  work_t push_data;
  work_t pop_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_source_depth    <= 32'd1 << FRACTION_BITS;
      cfg_q.virtual_source_depth <= 32'd1 << FRACTION_BITS;
      cfg_q.transport_extinction <= 32'd1 << FRACTION_BITS;
      cfg_q.query_x              <= '0;
      cfg_q.query_y              <= '0;
      cfg_q.query_z              <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REAL_DEPTH:    cfg_q.real_source_depth    <= cfg_data_i;
        CFG_VIRTUAL_DEPTH: cfg_q.virtual_source_depth <= cfg_data_i;
        CFG_EXTINCTION:    cfg_q.transport_extinction <= cfg_data_i;
        CFG_QUERY_X:       cfg_q.query_x              <= cfg_data_i;
        CFG_QUERY_Y:       cfg_q.query_y              <= cfg_data_i;
        CFG_QUERY_Z:       cfg_q.query_z              <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  dda_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  dda_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
